### hdl/tisync_pkg.sv
// shared types, widths and codes of the timer, interrupt hold and video sync block
package tisync_pkg;

   localparam int ACTION_W = 3;
   localparam int OFFSET_W = 6;
   localparam int DATA_W = 8;
   localparam int CYCLES_W = 7;
   localparam int CYC_MAX = (1 << CYCLES_W) - 1;

   localparam int TIMER_W = 21;
   localparam int LATCH_W = 16;
   localparam int THOLD_W = 10;
   localparam int KHOLD_W = 20;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 20;

   localparam int CYCLES_PER_LINE_DEF = 64;
   localparam int LINES_PER_FRAME_DEF = 312;

   localparam logic [THOLD_W-1:0] THOLD_RESET = 10'd100;
   localparam logic [KHOLD_W-1:0] KHOLD_RESET = 20'd500000;
   localparam logic [LATCH_W-1:0] LATCH_RESET = 16'hFFFF;
   localparam logic [TIMER_W-1:0] TIMER_RESET = 21'd65535;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK        = 3'd0,
      ACT_WRITE       = 3'd1,
      ACT_READ        = 3'd2,
      ACT_KEY_PRESS   = 3'd3,
      ACT_KEY_RELEASE = 3'd4
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMER_HOLD = 1'b0,
      CSR_KEY_HOLD   = 1'b1
   } csr_index_type;

   localparam logic [OFFSET_W-1:0] REG_STATUS    = 6'h00;
   localparam logic [OFFSET_W-1:0] REG_KEY_ACK   = 6'h03;
   localparam logic [OFFSET_W-1:0] REG_CONTROL   = 6'h05;
   localparam logic [OFFSET_W-1:0] REG_LATCH_HI  = 6'h06;
   localparam logic [OFFSET_W-1:0] REG_LATCH_LO  = 6'h07;
   localparam logic [OFFSET_W-1:0] REG_LINE_STAT = 6'h0A;
   localparam logic [OFFSET_W-1:0] REG_MODE      = 6'h24;
   localparam logic [OFFSET_W-1:0] REG_SYNC      = 6'h27;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [OFFSET_W-1:0] reg_offset;
      logic [DATA_W-1:0]   data;
      logic [CYCLES_W-1:0] cycles;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq_line;
   } rsp_item_type;

endpackage

### hdl/tisync_ifs.sv
// channel interfaces: request, response and configuration write
interface tisync_req_if;
   logic                             valid;
   logic                             ready;
   logic [tisync_pkg::ACTION_W-1:0]  action;
   logic [tisync_pkg::OFFSET_W-1:0]  reg_offset;
   logic [tisync_pkg::DATA_W-1:0]    data;
   logic [tisync_pkg::CYCLES_W-1:0]  cycles;

   modport source (output valid, action, reg_offset, data, cycles, input ready);
   modport sink (input valid, action, reg_offset, data, cycles, output ready);
endinterface

interface tisync_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tisync_pkg::DATA_W-1:0]  read_data;
   logic                           irq_line;

   modport source (output valid, read_data, irq_line, input ready);
   modport sink (input valid, read_data, irq_line, output ready);
endinterface

interface tisync_csr_if;
   logic                               valid;
   logic                               ready;
   logic [tisync_pkg::CSR_IDX_W-1:0]   idx;
   logic [tisync_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, idx, wdata, input ready);
   modport sink (input valid, idx, wdata, output ready);
endinterface

### hdl/tisync_in_stage.sv
// input register holding one accepted request transaction
module tisync_in_stage (
   input  logic                     clock,
   input  logic                     reset,
   tisync_req_if.sink               req_chan,
   input  logic                     pop,
   output logic                     item_valid,
   output tisync_pkg::req_item_type item
);

   logic                     valid_ff;
   logic                     valid_in;
   tisync_pkg::req_item_type item_ff;
   logic                     take;

   assign req_chan.ready = !valid_ff || pop;
   assign take = req_chan.valid && req_chan.ready;
   assign valid_in = take || (valid_ff && !pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{action: req_chan.action, reg_offset: req_chan.reg_offset,
                      data: req_chan.data, cycles: req_chan.cycles};
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

### hdl/tisync_core.sv
// state registers and the single-pass update for one transaction
module tisync_core #(
   parameter int CYCLES_PER_LINE = tisync_pkg::CYCLES_PER_LINE_DEF,
   parameter int LINES_PER_FRAME = tisync_pkg::LINES_PER_FRAME_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   tisync_csr_if.sink               csr_chan,
   input  logic                     fire,
   input  tisync_pkg::req_item_type item,
   output tisync_pkg::rsp_item_type result
);

   localparam int LC_W = $clog2(CYCLES_PER_LINE);
   localparam int LN_W = $clog2(LINES_PER_FRAME);
   localparam int LC_SUM_W = $clog2(CYCLES_PER_LINE + tisync_pkg::CYC_MAX);
   localparam int LINE_STEPS = (CYCLES_PER_LINE - 1 + tisync_pkg::CYC_MAX) / CYCLES_PER_LINE;

   logic [tisync_pkg::THOLD_W-1:0] timer_irq_hold_ff;
   logic [tisync_pkg::KHOLD_W-1:0] key_irq_hold_ff;

   logic [7:0]                     status_ff, status_in;
   logic [7:0]                     control_ff, control_in;
   logic [tisync_pkg::LATCH_W-1:0] latch_ff, latch_in;
   logic [tisync_pkg::TIMER_W-1:0] timer_ff, timer_in;
   logic [tisync_pkg::THOLD_W-1:0] thold_ff, thold_in;
   logic [tisync_pkg::KHOLD_W-1:0] khold_ff, khold_in;
   logic [LC_W-1:0]                line_cycle_ff, line_cycle_in;
   logic [LN_W-1:0]                line_number_ff, line_number_in;
   logic                           mode_ff, mode_in;
   logic                           irq_ff, irq_in;

   logic [7:0]                     lc8;
   logic [9:0]                     ln10;
   logic                           line_sync;
   logic                           frame_sync;
   logic [tisync_pkg::TIMER_W-1:0] reload;

   assign csr_chan.ready = 1'b1;
   assign reload = {2'b00, latch_ff, 3'b000};

   // beam position decode, widened to fixed compare widths
   assign lc8 = 8'(line_cycle_ff);
   assign ln10 = 10'(line_number_ff);
   assign line_sync = !(lc8 < 8'd11 || lc8 > 8'd51);
   always_comb begin
      frame_sync = 1'b1;
      if (ln10 < 10'd56 || ln10 > 10'd255) begin
         frame_sync = 1'b0;
      end else if (ln10 == 10'd56 && lc8 < 8'd12) begin
         frame_sync = 1'b0;
      end else if (ln10 == 10'd255 && lc8 > 8'd50) begin
         frame_sync = 1'b0;
      end
   end

   always_comb begin
      logic [LC_SUM_W-1:0]            lc_sum;
      logic [9:0]                     dec;
      logic [tisync_pkg::DATA_W-1:0]  rd;

      status_in = status_ff;
      control_in = control_ff;
      latch_in = latch_ff;
      timer_in = timer_ff;
      thold_in = thold_ff;
      khold_in = khold_ff;
      line_cycle_in = line_cycle_ff;
      line_number_in = line_number_ff;
      mode_in = mode_ff;
      irq_in = irq_ff;
      rd = '0;
      lc_sum = LC_SUM_W'(line_cycle_ff) + LC_SUM_W'(item.cycles);
      dec = '0;

      unique case (item.action)
         tisync_pkg::ACT_TICK: begin
            // one subtract per line crossed
            for (int i = 0; i < LINE_STEPS; i++) begin
               if (lc_sum >= LC_SUM_W'(CYCLES_PER_LINE)) begin
                  lc_sum = lc_sum - LC_SUM_W'(CYCLES_PER_LINE);
                  line_number_in = (line_number_in == LN_W'(LINES_PER_FRAME - 1)) ?
                                   '0 : line_number_in + 1'b1;
               end
            end
            line_cycle_in = LC_W'(lc_sum);

            thold_in = (thold_ff > 10'(item.cycles)) ? thold_ff - 10'(item.cycles) : '0;
            if (thold_in == '0) status_in[0] = 1'b0;
            khold_in = (khold_ff > 20'(item.cycles)) ? khold_ff - 20'(item.cycles) : '0;
            if (khold_in == '0) status_in[1] = 1'b0;
            if (status_in[2:0] == 3'b000) begin
               status_in[7] = 1'b0;
               irq_in = 1'b0;
            end

            if (!control_ff[0]) begin
               dec = control_ff[2] ? 10'(item.cycles) : {item.cycles, 3'b000};
            end
            // reload also catches a countdown past zero
            if (timer_ff <= 21'(dec) + 21'd5) begin
               thold_in = timer_irq_hold_ff;
               timer_in = reload;
               status_in = status_in | 8'h81;
               irq_in = 1'b1;
            end else begin
               timer_in = timer_ff - 21'(dec);
            end
         end
         tisync_pkg::ACT_WRITE: begin
            unique case (item.reg_offset)
               tisync_pkg::REG_STATUS: status_in = item.data;
               tisync_pkg::REG_KEY_ACK: if (!item.data[5]) khold_in = '0;
               tisync_pkg::REG_CONTROL: begin
                  control_in = item.data;
                  if (item.data[0]) timer_in = reload;
               end
               tisync_pkg::REG_LATCH_HI: latch_in = {item.data, latch_ff[7:0]};
               tisync_pkg::REG_LATCH_LO: latch_in = {latch_ff[15:8], item.data};
               tisync_pkg::REG_MODE: mode_in = item.data[0];
               default: ;
            endcase
         end
         tisync_pkg::ACT_READ: begin
            unique case (item.reg_offset)
               tisync_pkg::REG_STATUS: rd = (status_ff != '0) ? (status_ff | 8'h80) : '0;
               tisync_pkg::REG_CONTROL: rd = control_ff;
               tisync_pkg::REG_LATCH_HI: rd = timer_ff[18:11];
               tisync_pkg::REG_LATCH_LO: rd = timer_ff[10:3];
               tisync_pkg::REG_LINE_STAT: rd = (ln10 < 10'd200) ? 8'h00 : 8'h02;
               tisync_pkg::REG_SYNC: rd = {frame_sync, 1'b0, line_sync, 4'b0000, mode_ff};
               default: ;
            endcase
         end
         tisync_pkg::ACT_KEY_PRESS: begin
            status_in = status_ff | 8'h82;
            khold_in = key_irq_hold_ff;
            irq_in = 1'b1;
         end
         tisync_pkg::ACT_KEY_RELEASE: khold_in = '0;
         default: ;
      endcase

      result = '{read_data: rd, irq_line: irq_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_irq_hold_ff <= tisync_pkg::THOLD_RESET;
         key_irq_hold_ff <= tisync_pkg::KHOLD_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.idx)
            tisync_pkg::CSR_TIMER_HOLD:
               timer_irq_hold_ff <= csr_chan.wdata[tisync_pkg::THOLD_W-1:0];
            tisync_pkg::CSR_KEY_HOLD: key_irq_hold_ff <= csr_chan.wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
         control_ff <= '0;
         latch_ff <= tisync_pkg::LATCH_RESET;
         timer_ff <= tisync_pkg::TIMER_RESET;
         thold_ff <= '0;
         khold_ff <= '0;
         line_cycle_ff <= '0;
         line_number_ff <= '0;
         mode_ff <= 1'b0;
         irq_ff <= 1'b0;
      end else if (fire) begin
         status_ff <= status_in;
         control_ff <= control_in;
         latch_ff <= latch_in;
         timer_ff <= timer_in;
         thold_ff <= thold_in;
         khold_ff <= khold_in;
         line_cycle_ff <= line_cycle_in;
         line_number_ff <= line_number_in;
         mode_ff <= mode_in;
         irq_ff <= irq_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_line_cycle_range: assert property (@(posedge clock) disable iff (reset)
      lc8 < 8'(CYCLES_PER_LINE))
      else $error("line cycle out of range");

   a_line_number_range: assert property (@(posedge clock) disable iff (reset)
      ln10 < 10'(LINES_PER_FRAME))
      else $error("line number out of range");

   a_key_press_irq: assert property (@(posedge clock) disable iff (reset)
      (fire && item.action == tisync_pkg::ACT_KEY_PRESS) |=> (irq_ff && status_ff[1]))
      else $error("key press did not raise the interrupt");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(timer_ff) && $stable(status_ff) && $stable(irq_ff)))
      else $error("state changed without a transaction");
`endif

endmodule

### hdl/tisync_out_stage.sv
// result register feeding the response channel
module tisync_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  tisync_pkg::rsp_item_type result,
   output logic                     can_load,
   tisync_rsp_if.source             rsp_chan
);

   logic                     valid_ff;
   logic                     valid_in;
   tisync_pkg::rsp_item_type result_ff;

   assign can_load = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.read_data = result_ff.read_data;
   assign rsp_chan.irq_line = result_ff.irq_line;

endmodule

### hdl/timer_irq_video_sync.sv
// Interval timer with interrupt hold counters and video line/frame position counters.
// Takes one request transaction per clock while the response side is not stalled: a
// transaction is registered in the input register at acceptance, its whole state update
// runs in one combinational pass once the result register can load, and its response is
// registered in the result register as the state registers update. The sustained rate
// is one transaction per cycle, set by the single update pass between the input register
// and the result register. A response waiting on
// a stalled consumer still lets one more request enter the input register.
// Configuration writes are always ready and take effect at once.
module timer_irq_video_sync #(
   parameter int CYCLES_PER_LINE = tisync_pkg::CYCLES_PER_LINE_DEF,
   parameter int LINES_PER_FRAME = tisync_pkg::LINES_PER_FRAME_DEF
) (
   input  logic         clock,
   input  logic         reset,
   tisync_req_if.sink   req_chan,
   tisync_rsp_if.source rsp_chan,
   tisync_csr_if.sink   csr_chan
);

   logic                     item_valid;
   tisync_pkg::req_item_type item;
   tisync_pkg::rsp_item_type result;
   logic                     can_load;
   logic                     fire;

   assign fire = item_valid && can_load;

   tisync_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .pop        (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   tisync_core #(
      .CYCLES_PER_LINE (CYCLES_PER_LINE),
      .LINES_PER_FRAME (LINES_PER_FRAME)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .fire     (fire),
      .item     (item),
      .result   (result)
   );

   tisync_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (fire),
      .result   (result),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

### test/tb.sv
// testbench for timer_irq_video_sync: random and directed bus, tick and key traffic with a scoreboard
`timescale 1ns / 1ps

module tb;

   typedef logic [tisync_pkg::ACTION_W-1:0]   act_field_type;
   typedef logic [tisync_pkg::OFFSET_W-1:0]   offset_type;
   typedef logic [tisync_pkg::DATA_W-1:0]     data_type;
   typedef logic [tisync_pkg::CYCLES_W-1:0]   cycles_type;
   typedef logic [tisync_pkg::CSR_DATA_W-1:0] csr_data_type;

   localparam act_field_type ACT_RESERVED_FIRST = 3'd5;
   localparam act_field_type ACT_RESERVED_LAST  = 3'd7;
   localparam offset_type    REG_UNMAPPED       = 6'h3F;

   localparam logic [7:0] FLAG_TIMER = 8'h01;
   localparam logic [7:0] FLAG_KEY   = 8'h02;
   localparam logic [7:0] FLAG_PORT2 = 8'h04;
   localparam logic [7:0] FLAG_ANY   = 8'h80;
   localparam logic [7:0] SYNC_LINE  = 8'h20;
   localparam logic [7:0] SYNC_FRAME = 8'h80;
   localparam logic [7:0] LOWER_AREA = 8'h02;
   localparam int RELOAD_FLOOR = 5;
   localparam int LOWER_AREA_LINE = 200;
   localparam int ITEMS_PER_PHASE = 180;
   localparam int PHASES = 5;
   localparam int RSP_HOLD_OFF = 200;
   localparam int HOLD_OFF_AFTER = 350;

   class tisync_scoreboard;
      logic [tisync_pkg::THOLD_W-1:0] timer_hold_cfg;
      logic [tisync_pkg::KHOLD_W-1:0] key_hold_cfg;
      logic [7:0]                     flags;
      logic [7:0]                     ctrl;
      logic [tisync_pkg::LATCH_W-1:0] latch;
      logic [tisync_pkg::TIMER_W-1:0] count;
      logic [tisync_pkg::THOLD_W-1:0] thold_left;
      logic [tisync_pkg::KHOLD_W-1:0] khold_left;
      logic [5:0]                     beam_x;
      logic [8:0]                     beam_y;
      logic                           mode;
      logic                           irq;
      tisync_pkg::rsp_item_type       bus_results_q[$];
      int                             mismatches;

      function new();
         timer_hold_cfg = tisync_pkg::THOLD_RESET;
         key_hold_cfg = tisync_pkg::KHOLD_RESET;
         flags = '0;
         ctrl = '0;
         latch = tisync_pkg::LATCH_RESET;
         count = tisync_pkg::TIMER_RESET;
         thold_left = '0;
         khold_left = '0;
         beam_x = '0;
         beam_y = '0;
         mode = 1'b0;
         irq = 1'b0;
         mismatches = 0;
      endfunction

      function void set_hold(tisync_pkg::csr_index_type idx, csr_data_type value);
         if (idx == tisync_pkg::CSR_TIMER_HOLD)
            timer_hold_cfg = value[tisync_pkg::THOLD_W-1:0];
         else
            key_hold_cfg = value[tisync_pkg::KHOLD_W-1:0];
      endfunction

      function logic [7:0] line_sync();
         return (beam_x < 11 || beam_x > 51) ? 8'h00 : SYNC_LINE;
      endfunction

      function logic [7:0] frame_sync();
         // visible window runs from line 56 at beam_x 12 to line 255 at beam_x 50
         if (beam_y < 56 || beam_y > 255) return 8'h00;
         if (beam_y == 56 && beam_x < 12) return 8'h00;
         if (beam_y == 255 && beam_x > 50) return 8'h00;
         return SYNC_FRAME;
      endfunction

      function void advance_beam_and_timer(cycles_type cyc);
         int x;
         int step;
         x = int'(beam_x) + int'(cyc);
         while (x >= tisync_pkg::CYCLES_PER_LINE_DEF) begin
            x -= tisync_pkg::CYCLES_PER_LINE_DEF;
            beam_y = (int'(beam_y) + 1 >= tisync_pkg::LINES_PER_FRAME_DEF) ?
                     9'd0 : beam_y + 9'd1;
         end
         beam_x = x[5:0];

         thold_left = (thold_left > cyc) ? thold_left - cyc : '0;
         if (thold_left == 0) flags &= ~FLAG_TIMER;
         khold_left = (khold_left > cyc) ? khold_left - cyc : '0;
         if (khold_left == 0) flags &= ~FLAG_KEY;
         if ((flags & (FLAG_TIMER | FLAG_KEY | FLAG_PORT2)) == 0) begin
            flags &= ~FLAG_ANY;
            irq = 1'b0;
         end

         // reload test runs even while the timer is stopped
         step = 0;
         if (!ctrl[0]) step = ctrl[2] ? int'(cyc) : int'(cyc) * 8;
         if (int'(count) <= step + RELOAD_FLOOR) begin
            thold_left = timer_hold_cfg;
            count = {latch, 3'b000};
            flags |= FLAG_ANY | FLAG_TIMER;
            irq = 1'b1;
         end else begin
            count -= step;
         end
      endfunction

      function void bus_write(offset_type off, data_type d);
         case (off)
            tisync_pkg::REG_STATUS: flags = d;
            tisync_pkg::REG_KEY_ACK: if (!d[5]) khold_left = '0;
            tisync_pkg::REG_CONTROL: begin
               ctrl = d;
               if (d[0]) count = {latch, 3'b000};
            end
            tisync_pkg::REG_LATCH_HI: latch[15:8] = d;
            tisync_pkg::REG_LATCH_LO: latch[7:0] = d;
            tisync_pkg::REG_MODE: mode = d[0];
            default: ;
         endcase
      endfunction

      function data_type bus_read(offset_type off);
         case (off)
            tisync_pkg::REG_STATUS: return (flags != 0) ? (flags | FLAG_ANY) : 8'h00;
            tisync_pkg::REG_CONTROL: return ctrl;
            tisync_pkg::REG_LATCH_HI: return count[18:11];
            tisync_pkg::REG_LATCH_LO: return count[10:3];
            tisync_pkg::REG_LINE_STAT:
               return (beam_y < LOWER_AREA_LINE) ? 8'h00 : LOWER_AREA;
            tisync_pkg::REG_SYNC: return {7'b0, mode} | frame_sync() | line_sync();
            default: return 8'h00;
         endcase
      endfunction

      function void note_request(act_field_type act, offset_type off,
                                 data_type d, cycles_type cyc);
         tisync_pkg::rsp_item_type exp_rsp;
         exp_rsp.read_data = '0;
         case (act)
            tisync_pkg::ACT_TICK: advance_beam_and_timer(cyc);
            tisync_pkg::ACT_WRITE: bus_write(off, d);
            tisync_pkg::ACT_READ: exp_rsp.read_data = bus_read(off);
            tisync_pkg::ACT_KEY_PRESS: begin
               flags |= FLAG_ANY | FLAG_KEY;
               khold_left = key_hold_cfg;
               irq = 1'b1;
            end
            tisync_pkg::ACT_KEY_RELEASE: khold_left = '0;
            default: ;
         endcase
         exp_rsp.irq_line = irq;
         bus_results_q.push_back(exp_rsp);
      endfunction

      function void check_response(data_type rd, logic irq_out);
         tisync_pkg::rsp_item_type exp_rsp;
         if (bus_results_q.size() == 0) begin
            $error("response with nothing outstanding: read_data %02h irq_line %0b",
                   rd, irq_out);
            mismatches++;
         end else begin
            exp_rsp = bus_results_q.pop_front();
            if (rd !== exp_rsp.read_data) begin
               $error("read_data expected %02h actual %02h", exp_rsp.read_data, rd);
               mismatches++;
            end
            if (irq_out !== exp_rsp.irq_line) begin
               $error("irq_line expected %0b actual %0b", exp_rsp.irq_line, irq_out);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   requests_taken;
   bit   req_no_gaps;
   tisync_scoreboard sb;

   tisync_req_if req_if();
   tisync_rsp_if rsp_if();
   tisync_csr_if csr_if();

   timer_irq_video_sync u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #20_000_000;
      $display("timer_irq_video_sync verification failed");
      $finish;
   end

   // both channels are observed here, pre-edge values only
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         sb.note_request(req_if.action, req_if.reg_offset, req_if.data, req_if.cycles);
         requests_taken++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_response(rsp_if.read_data, rsp_if.irq_line);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // response side: ready bursts, random gaps, one long hold-off so the block backs up
   initial begin : rsp_pacing
      int run;
      int gap;
      bit held;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && requests_taken >= HOLD_OFF_AFTER) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_OFF) @(negedge clock);
         end
         run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
         rsp_if.ready <= 1'b1;
         repeat (run) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // starts and ends on a falling edge; valid stays high into the next call
   task automatic send_request(input act_field_type act,
                               input offset_type off,
                               input data_type d,
                               input cycles_type cyc);
      int gap;
      gap = req_no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.action <= act;
      req_if.reg_offset <= off;
      req_if.data <= d;
      req_if.cycles <= cyc;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic program_holds(input csr_data_type timer_hold,
                                input csr_data_type key_hold);
      csr_if.idx <= tisync_pkg::CSR_TIMER_HOLD;
      csr_if.wdata <= timer_hold;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      sb.set_hold(tisync_pkg::CSR_TIMER_HOLD, timer_hold);
      @(negedge clock);
      csr_if.idx <= tisync_pkg::CSR_KEY_HOLD;
      csr_if.wdata <= key_hold;
      do @(posedge clock); while (!csr_if.ready);
      sb.set_hold(tisync_pkg::CSR_KEY_HOLD, key_hold);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      while (sb.bus_results_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic offset_type pick_read_offset();
      case ($urandom_range(0, 9))
         0: return tisync_pkg::REG_STATUS;
         1: return tisync_pkg::REG_CONTROL;
         2: return tisync_pkg::REG_LATCH_HI;
         3: return tisync_pkg::REG_LATCH_LO;
         4, 5: return tisync_pkg::REG_LINE_STAT;
         6, 7: return tisync_pkg::REG_SYNC;
         default: return offset_type'($urandom);
      endcase
   endfunction

   function automatic tisync_pkg::req_item_type random_request();
      tisync_pkg::req_item_type r;
      int pick;
      r.action = tisync_pkg::ACT_TICK;
      r.reg_offset = offset_type'($urandom);
      r.data = data_type'($urandom);
      r.cycles = cycles_type'($urandom_range(0, 64));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         case ($urandom_range(0, 6))
            0: r.cycles = cycles_type'($urandom_range(0, 3));
            1: r.cycles = cycles_type'($urandom_range(65, tisync_pkg::CYC_MAX));
            default: ;
         endcase
      end else if (pick < 62) begin
         r.action = tisync_pkg::ACT_READ;
         r.reg_offset = pick_read_offset();
      end else if (pick < 84) begin
         r.action = tisync_pkg::ACT_WRITE;
         case ($urandom_range(0, 9))
            0: r.reg_offset = tisync_pkg::REG_STATUS;
            1: r.reg_offset = tisync_pkg::REG_KEY_ACK;
            2, 3: begin
               r.reg_offset = tisync_pkg::REG_CONTROL;
               if ($urandom_range(0, 3) != 0) r.data[0] = 1'b0;
            end
            4: begin
               r.reg_offset = tisync_pkg::REG_LATCH_HI;
               if ($urandom_range(0, 4) != 0) r.data = data_type'($urandom_range(0, 1));
            end
            5: r.reg_offset = tisync_pkg::REG_LATCH_LO;
            6: r.reg_offset = tisync_pkg::REG_MODE;
            default: ;
         endcase
      end else if (pick < 90) begin
         r.action = tisync_pkg::ACT_KEY_PRESS;
      end else if (pick < 96) begin
         r.action = tisync_pkg::ACT_KEY_RELEASE;
      end else if (pick < 98) begin
         r.action = act_field_type'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST));
      end else begin
         r.action = act_field_type'($urandom_range(0, 7));
         r.cycles = cycles_type'($urandom_range(0, tisync_pkg::CYC_MAX));
      end
      return r;
   endfunction

   initial begin
      tisync_pkg::req_item_type r;
      int sent;
      sb = new();
      requests_taken = 0;
      req_no_gaps = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.action = tisync_pkg::ACT_TICK;
      req_if.reg_offset = '0;
      req_if.data = '0;
      req_if.cycles = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.idx = tisync_pkg::CSR_TIMER_HOLD;
      csr_if.wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every register, every action, long tick, reload, stale status flags
      send_request(tisync_pkg::ACT_READ, tisync_pkg::REG_SYNC, 8'h00, 7'd0);
      send_request(tisync_pkg::ACT_WRITE, tisync_pkg::REG_MODE, 8'hFF, 7'd0);
      send_request(tisync_pkg::ACT_READ, tisync_pkg::REG_SYNC, 8'h00, 7'd0);
      send_request(tisync_pkg::ACT_WRITE, tisync_pkg::REG_LATCH_HI, 8'h00, 7'd0);
      send_request(tisync_pkg::ACT_WRITE, tisync_pkg::REG_LATCH_LO, 8'h10, 7'd0);
      send_request(tisync_pkg::ACT_WRITE, tisync_pkg::REG_CONTROL, 8'h01, 7'd0);
      send_request(tisync_pkg::ACT_READ, tisync_pkg::REG_LATCH_HI, 8'h00, 7'd0);
      send_request(tisync_pkg::ACT_READ, tisync_pkg::REG_LATCH_LO, 8'h00, 7'd0);
      send_request(tisync_pkg::ACT_TICK, tisync_pkg::REG_STATUS, 8'h00,
                   7'(tisync_pkg::CYC_MAX));
      send_request(tisync_pkg::ACT_WRITE, tisync_pkg::REG_CONTROL, 8'h04, 7'd0);
      send_request(tisync_pkg::ACT_TICK, tisync_pkg::REG_STATUS, 8'h00, 7'd64);
      send_request(tisync_pkg::ACT_TICK, tisync_pkg::REG_STATUS, 8'h00, 7'd64);
      send_request(tisync_pkg::ACT_READ, tisync_pkg::REG_STATUS, 8'h00, 7'd0);
      send_request(tisync_pkg::ACT_TICK, tisync_pkg::REG_STATUS, 8'h00, 7'd0);
      send_request(tisync_pkg::ACT_WRITE, tisync_pkg::REG_CONTROL, 8'h00, 7'd0);
      send_request(tisync_pkg::ACT_KEY_PRESS, tisync_pkg::REG_STATUS, 8'h00, 7'd0);
      send_request(tisync_pkg::ACT_WRITE, tisync_pkg::REG_KEY_ACK, 8'h20, 7'd0);
      send_request(tisync_pkg::ACT_WRITE, tisync_pkg::REG_KEY_ACK, 8'h00, 7'd0);
      send_request(tisync_pkg::ACT_KEY_RELEASE, tisync_pkg::REG_STATUS, 8'h00, 7'd0);
      send_request(tisync_pkg::ACT_WRITE, tisync_pkg::REG_STATUS, 8'hFF, 7'd0);
      send_request(tisync_pkg::ACT_TICK, tisync_pkg::REG_STATUS, 8'h00, 7'd1);
      send_request(tisync_pkg::ACT_WRITE, REG_UNMAPPED, 8'hAA, 7'd0);
      send_request(tisync_pkg::ACT_READ, REG_UNMAPPED, 8'h00, 7'd0);
      send_request(ACT_RESERVED_LAST, tisync_pkg::REG_STATUS, 8'hFF,
                   7'(tisync_pkg::CYC_MAX));
      send_request(tisync_pkg::ACT_READ, tisync_pkg::REG_LINE_STAT, 8'h00, 7'd0);
      send_request(tisync_pkg::ACT_READ, tisync_pkg::REG_CONTROL, 8'h00, 7'd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         case (phase)
            0: program_holds(20'd0, 20'd0);
            1: program_holds(20'd1023, 20'hFFFFF);
            2: program_holds(20'd1, 20'd1);
            3: program_holds(csr_data_type'($urandom_range(0, 1023)),
                             csr_data_type'($urandom_range(0, 20'hFFFFF)));
            default: program_holds(csr_data_type'($urandom_range(0, 1023)),
                                   csr_data_type'($urandom_range(50, 3000)));
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if (sent % 30 == 0) req_no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 24) == 0) begin
               // reprogram the timer with a short period and let it run
               send_request(tisync_pkg::ACT_WRITE, tisync_pkg::REG_LATCH_HI,
                            data_type'($urandom_range(0, 1)), 7'd0);
               send_request(tisync_pkg::ACT_WRITE, tisync_pkg::REG_LATCH_LO,
                            data_type'($urandom), 7'd0);
               send_request(tisync_pkg::ACT_WRITE, tisync_pkg::REG_CONTROL, 8'h01, 7'd0);
               send_request(tisync_pkg::ACT_WRITE, tisync_pkg::REG_CONTROL,
                            data_type'($urandom) & 8'hFE, 7'd0);
               sent += 4;
            end else begin
               r = random_request();
               send_request(r.action, r.reg_offset, r.data, r.cycles);
               sent++;
            end
         end
      end

      wait_for_results();
      repeat (10) @(negedge clock);
      if (sb.mismatches == 0 && sb.bus_results_q.size() == 0)
         $display("timer_irq_video_sync verification clean");
      else
         $display("timer_irq_video_sync verification failed");
      $finish;
   end

endmodule

### files.f
hdl/tisync_pkg.sv
hdl/tisync_ifs.sv
hdl/tisync_in_stage.sv
hdl/tisync_core.sv
hdl/tisync_out_stage.sv
hdl/timer_irq_video_sync.sv
test/tb.sv
